### rtl/nibble_mouse_packet_cursor_tracker_defines.svh
// Assertion helpers for the checker file.
`ifndef NIBBLE_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define NIBBLE_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

// Clocked property, disabled while reset is low.
`define NMPCT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define NMPCT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/nmpct_pkg.sv
`default_nettype none

package nmpct_pkg;

  localparam int unsigned PACKET_NIBBLES_DEF = 9;
  localparam int unsigned FIFO_DEPTH_DEF     = 2;

  localparam int unsigned NIB_W   = 4;
  localparam int unsigned MAG_W   = 8;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned DELTA_W = 9;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [NIB_W-1:0] SIG_NIB0 = 4'hB;
  localparam logic [NIB_W-1:0] SIG_NIB1 = 4'hF;
  localparam logic [NIB_W-1:0] SIG_NIB2 = 4'hF;

  localparam logic [MAG_W-1:0] MAX_DELTA_RST = 8'd30;
  localparam logic [POS_W-1:0] X_MIN_RST     = 9'd0;
  localparam logic [POS_W-1:0] X_MAX_RST     = 9'd311;
  localparam logic [POS_W-1:0] Y_MIN_RST     = 9'd112;
  localparam logic [POS_W-1:0] Y_MAX_RST     = 9'd215;
  localparam logic [POS_W-1:0] POS_X_RST     = 9'd160;
  localparam logic [POS_W-1:0] POS_Y_RST     = 9'd168;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_DELTA = 3'd0,
    CFG_X_MIN     = 3'd1,
    CFG_X_MAX     = 3'd2,
    CFG_Y_MIN     = 3'd3,
    CFG_Y_MAX     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic             ok;
    logic             sign_x;
    logic             sign_y;
    logic [NIB_W-1:0] buttons;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
  } pkt_t;

endpackage

`default_nettype wire

### rtl/nmpct_in_if.sv
`default_nettype none

interface nmpct_in_if import nmpct_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [NIB_W-1:0] nibble;
  logic             first;

  modport source (output valid, output nibble, output first, input ready);
  modport sink   (input valid, input nibble, input first, output ready);
endinterface

`default_nettype wire

### rtl/nmpct_out_if.sv
`default_nettype none

interface nmpct_out_if import nmpct_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic                      packet_ok;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;
  logic [NIB_W-1:0]          buttons;
  logic                      glitch;
  logic [POS_W-1:0]          cursor_x;
  logic [POS_W-1:0]          cursor_y;
  logic signed [SUM_W-1:0]   total_x;
  logic signed [SUM_W-1:0]   total_y;
  logic [CNT_W-1:0]          ok_count;
  logic [CNT_W-1:0]          fail_count;
  logic [CNT_W-1:0]          glitch_count;

  modport source (
    output valid, output packet_ok, output delta_x, output delta_y, output buttons,
    output glitch, output cursor_x, output cursor_y, output total_x, output total_y,
    output ok_count, output fail_count, output glitch_count, input ready
  );
  modport sink (
    input valid, input packet_ok, input delta_x, input delta_y, input buttons,
    input glitch, input cursor_x, input cursor_y, input total_x, input total_y,
    input ok_count, input fail_count, input glitch_count, output ready
  );
endinterface

`default_nettype wire

### rtl/nmpct_cfg_if.sv
`default_nettype none

interface nmpct_cfg_if import nmpct_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/nmpct_fifo.sv
`default_nettype none

module nmpct_fifo import nmpct_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_valid_i,
  output logic      wr_ready_o,
  input  wire pkt_t wr_data_i,
  output logic      rd_valid_o,
  input  wire logic rd_ready_i,
  output pkt_t      rd_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_FW = $clog2(DEPTH + 1);

  pkt_t              mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_FW-1:0] count_q, count_d;
  logic              push, pop;

  assign wr_ready_o = (count_q != CNT_FW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/nmpct_front.sv
`default_nettype none

module nmpct_front import nmpct_pkg::*; #(
  parameter int unsigned PACKET_NIBBLES = PACKET_NIBBLES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  nmpct_in_if.sink   in_i,
  output logic       push_valid_o,
  input  wire logic  push_ready_i,
  output pkt_t       push_data_o
);

  localparam int unsigned POS_CW      = $clog2(PACKET_NIBBLES);
  localparam int unsigned STORE_DEPTH = PACKET_NIBBLES - 1;
  localparam int unsigned STORE_W     = $clog2(STORE_DEPTH);

  logic [NIB_W-1:0]  store_q [STORE_DEPTH];
  logic [POS_CW-1:0] pos_q, pos_d;
  logic [POS_CW-1:0] cur;
  logic              fire, last;

  assign in_i.ready = push_ready_i;
  assign fire       = in_i.valid && in_i.ready;
  assign cur        = in_i.first ? '0 : pos_q;
  assign last       = (cur == POS_CW'(PACKET_NIBBLES - 1));

  assign push_valid_o = fire && last;

  // nibble 8 comes straight from the port
  always_comb begin
    push_data_o.ok      = (store_q[0] == SIG_NIB0) && (store_q[1] == SIG_NIB1) &&
                          (store_q[2] == SIG_NIB2);
    push_data_o.sign_x  = store_q[3][0];
    push_data_o.sign_y  = store_q[3][1];
    push_data_o.buttons = store_q[4];
    push_data_o.mag_x   = {store_q[5], store_q[6]};
    push_data_o.mag_y   = {store_q[7], in_i.nibble};
  end

  always_comb begin
    pos_d = pos_q;
    if (fire) begin
      pos_d = last ? '0 : cur + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !last) begin
      store_q[cur[STORE_W-1:0]] <= in_i.nibble;
    end
  end

endmodule

`default_nettype wire

### rtl/nmpct_back.sv
`default_nettype none

module nmpct_back import nmpct_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  nmpct_cfg_if.sink   cfg_i,
  input  wire logic   pkt_valid_i,
  output logic        pkt_ready_o,
  input  wire pkt_t   pkt_i,
  nmpct_out_if.source out_o
);

  logic [MAG_W-1:0] max_delta_q;
  logic [POS_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;

  logic [POS_W-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CNT_W-1:0] ok_cnt_q, fail_cnt_q, glitch_cnt_q;

  logic                      out_valid_q;
  logic                      ok_q, glitch_q;
  logic [NIB_W-1:0]          buttons_q;
  logic signed [DELTA_W-1:0] dx_q, dy_q;

  logic                      pop, glitch, apply;
  logic [NIB_W-1:0]          buttons;
  logic signed [DELTA_W-1:0] mag_x, mag_y, dx, dy;
  logic signed [POS_W+1:0]   vx, vy, lox, hix, loy, hiy, cx_lo, cy_lo, cx, cy;

  assign cfg_i.ready = 1'b1;

  assign pkt_ready_o = !out_valid_q || out_o.ready;
  assign pop         = pkt_valid_i && pkt_ready_o;

  always_comb begin
    glitch  = pkt_i.ok && ((pkt_i.mag_x > max_delta_q) || (pkt_i.mag_y > max_delta_q));
    apply   = pkt_i.ok && !glitch;
    buttons = pkt_i.ok ? pkt_i.buttons : '0;
    mag_x   = $signed({1'b0, pkt_i.mag_x});
    mag_y   = $signed({1'b0, pkt_i.mag_y});
    dx      = apply ? (pkt_i.sign_x ? -mag_x : mag_x) : '0;
    dy      = apply ? (pkt_i.sign_y ? -mag_y : mag_y) : '0;

    vx  = $signed({2'b00, pos_x_q}) + $signed({{2{dx[DELTA_W-1]}}, dx});
    vy  = $signed({2'b00, pos_y_q}) - $signed({{2{dy[DELTA_W-1]}}, dy});
    lox = $signed({2'b00, x_min_q});
    hix = $signed({2'b00, x_max_q});
    loy = $signed({2'b00, y_min_q});
    hiy = $signed({2'b00, y_max_q});
    // minimum first, maximum wins when bounds cross
    cx_lo = (vx < lox) ? lox : vx;
    cx    = (cx_lo > hix) ? hix : cx_lo;
    cy_lo = (vy < loy) ? loy : vy;
    cy    = (cy_lo > hiy) ? hiy : cy_lo;

    pos_x_d = cx[POS_W-1:0];
    pos_y_d = cy[POS_W-1:0];
    sum_x_d = sum_x_q + {{(SUM_W-DELTA_W){dx[DELTA_W-1]}}, dx};
    sum_y_d = sum_y_q + {{(SUM_W-DELTA_W){dy[DELTA_W-1]}}, dy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delta_q  <= MAX_DELTA_RST;
      x_min_q      <= X_MIN_RST;
      x_max_q      <= X_MAX_RST;
      y_min_q      <= Y_MIN_RST;
      y_max_q      <= Y_MAX_RST;
      pos_x_q      <= POS_X_RST;
      pos_y_q      <= POS_Y_RST;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      ok_cnt_q     <= '0;
      fail_cnt_q   <= '0;
      glitch_cnt_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_idx_e'(cfg_i.index))
          CFG_MAX_DELTA: max_delta_q <= cfg_i.data[MAG_W-1:0];
          CFG_X_MIN:     x_min_q     <= cfg_i.data[POS_W-1:0];
          CFG_X_MAX:     x_max_q     <= cfg_i.data[POS_W-1:0];
          CFG_Y_MIN:     y_min_q     <= cfg_i.data[POS_W-1:0];
          CFG_Y_MAX:     y_max_q     <= cfg_i.data[POS_W-1:0];
          default: ;
        endcase
      end
      if (pop) begin
        pos_x_q      <= pos_x_d;
        pos_y_q      <= pos_y_d;
        sum_x_q      <= sum_x_d;
        sum_y_q      <= sum_y_d;
        ok_cnt_q     <= ok_cnt_q + CNT_W'(pkt_i.ok);
        fail_cnt_q   <= fail_cnt_q + CNT_W'(!pkt_i.ok);
        glitch_cnt_q <= glitch_cnt_q + CNT_W'(glitch);
        out_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ok_q      <= pkt_i.ok;
      glitch_q  <= glitch;
      buttons_q <= buttons;
      dx_q      <= dx;
      dy_q      <= dy;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.packet_ok    = ok_q;
  assign out_o.delta_x      = dx_q;
  assign out_o.delta_y      = dy_q;
  assign out_o.buttons      = buttons_q;
  assign out_o.glitch       = glitch_q;
  assign out_o.cursor_x     = pos_x_q;
  assign out_o.cursor_y     = pos_y_q;
  assign out_o.total_x      = $signed(sum_x_q);
  assign out_o.total_y      = $signed(sum_y_q);
  assign out_o.ok_count     = ok_cnt_q;
  assign out_o.fail_count   = fail_cnt_q;
  assign out_o.glitch_count = glitch_cnt_q;

endmodule

`default_nettype wire

### rtl/nibble_mouse_packet_cursor_tracker.sv
// Takes one nibble per cycle; no stall while the output side keeps up.
// A result is queued on a packet's last nibble transfer, then registered to out_o;
// a two-entry packet queue between decoder and tracker absorbs output stalls.
// Reset: cursor to (160,168), totals and counts to zero, registers to defaults,
// nibble count to zero. Stored nibbles are not cleared.
`default_nettype none

module nibble_mouse_packet_cursor_tracker import nmpct_pkg::*; #(
  parameter int unsigned PACKET_NIBBLES = PACKET_NIBBLES_DEF,
  parameter int unsigned FIFO_DEPTH     = FIFO_DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  nmpct_in_if.sink    in_i,
  nmpct_cfg_if.sink   cfg_i,
  nmpct_out_if.source out_o
);

  logic push_valid, push_ready, pkt_valid, pkt_ready;
  pkt_t push_data, pkt_data;

  nmpct_front #(
    .PACKET_NIBBLES(PACKET_NIBBLES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  nmpct_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(push_valid),
    .wr_ready_o(push_ready),
    .wr_data_i (push_data),
    .rd_valid_o(pkt_valid),
    .rd_ready_i(pkt_ready),
    .rd_data_o (pkt_data)
  );

  nmpct_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .pkt_valid_i(pkt_valid),
    .pkt_ready_o(pkt_ready),
    .pkt_i      (pkt_data),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

### rtl/nmpct_checker.sv
`default_nettype none
`include "nibble_mouse_packet_cursor_tracker_defines.svh"

module nmpct_checker import nmpct_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  nmpct_out_if.source out_o
);

  logic                                 out_stall;
  logic [2*POS_W+2*SUM_W+2*CNT_W-1:0]   out_state;
  logic                                 out_moved;
  logic                                 bad_pkt_data;
  logic                                 glitch_moved;

  assign out_stall    = out_o.valid && !out_o.ready;
  assign out_state    = {out_o.cursor_x, out_o.cursor_y, out_o.total_x, out_o.total_y,
                         out_o.ok_count, out_o.glitch_count};
  assign out_moved    = (out_o.delta_x != '0) || (out_o.delta_y != '0);
  assign bad_pkt_data = out_o.valid && !out_o.packet_ok &&
                        (out_moved || (out_o.buttons != '0) || out_o.glitch);
  assign glitch_moved = out_o.valid && out_o.glitch && out_moved;

  `NMPCT_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_o.valid, "result dropped")
  `NMPCT_ASSERT(a_out_stable, clk_i, rst_ni, out_stall |=> $stable(out_state), "stalled result changed")
  `NMPCT_ASSERT_NEVER(a_bad_pkt_zero, clk_i, rst_ni, bad_pkt_data, "invalid packet carries data")
  `NMPCT_ASSERT_NEVER(a_glitch_zero, clk_i, rst_ni, glitch_moved, "glitch packet carries deltas")

endmodule

bind nibble_mouse_packet_cursor_tracker nmpct_checker u_nmpct_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .out_o (out_o)
);

`default_nettype wire

### bench/tb_nibble_mouse_packet_cursor_tracker.sv
`timescale 1ns / 100ps

module tb_nibble_mouse_packet_cursor_tracker;
  import nmpct_pkg::*;

  localparam int PHASE_ITEMS    = 190;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTED   = 10;
  localparam int DIR_ROWS       = 30;

  typedef struct packed {
    logic                      packet_ok;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic [NIB_W-1:0]          buttons;
    logic                      glitch;
    logic [POS_W-1:0]          cursor_x;
    logic [POS_W-1:0]          cursor_y;
    logic signed [SUM_W-1:0]   total_x;
    logic signed [SUM_W-1:0]   total_y;
    logic [CNT_W-1:0]          ok_count;
    logic [CNT_W-1:0]          fail_count;
    logic [CNT_W-1:0]          glitch_count;
  } cursor_report_t;

  // {first, nibble}: stray start, restart with negative-zero X, bad signature,
  // packet started by count wrap with full-scale magnitudes (glitch)
  localparam logic [NIB_W:0] DIR_TABLE [0:DIR_ROWS-1] = '{
    5'h1B, 5'h0F, 5'h0F,
    5'h1B, 5'h0F, 5'h0F, 5'h01, 5'h0A, 5'h00, 5'h00, 5'h01, 5'h0E,
    5'h1B, 5'h0F, 5'h0E, 5'h03, 5'h05, 5'h00, 5'h04, 5'h00, 5'h02,
    5'h0B, 5'h0F, 5'h0F, 5'h03, 5'h0F, 5'h0F, 5'h0F, 5'h0F, 5'h0F
  };

  localparam cursor_report_t DIR_REPORTS [0:2] = '{
    '{1'b1, 9'sd0, 9'sd30, 4'hA, 1'b0, 9'd160, 9'd138, 32'sd0, 32'sd30, 32'd1, 32'd0, 32'd0},
    '{1'b0, 9'sd0, 9'sd0, 4'h0, 1'b0, 9'd160, 9'd138, 32'sd0, 32'sd30, 32'd1, 32'd1, 32'd0},
    '{1'b1, 9'sd0, 9'sd0, 4'hF, 1'b1, 9'd160, 9'd138, 32'sd0, 32'sd30, 32'd2, 32'd1, 32'd1}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  nmpct_in_if  in_bus ();
  nmpct_cfg_if cfg_bus ();
  nmpct_out_if out_bus ();

  nibble_mouse_packet_cursor_tracker DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .cfg_i  (cfg_bus),
    .out_o  (out_bus)
  );

  always #10 clk_i = ~clk_i;

  // tracker shadow state
  logic [MAG_W-1:0] lim_max_delta = MAX_DELTA_RST;
  logic [POS_W-1:0] lim_x_min     = X_MIN_RST;
  logic [POS_W-1:0] lim_x_max     = X_MAX_RST;
  logic [POS_W-1:0] lim_y_min     = Y_MIN_RST;
  logic [POS_W-1:0] lim_y_max     = Y_MAX_RST;
  logic [NIB_W-1:0] nib_store [PACKET_NIBBLES_DEF];
  int unsigned      nib_pos    = 0;
  logic [POS_W-1:0] cur_x      = POS_X_RST;
  logic [POS_W-1:0] cur_y      = POS_Y_RST;
  logic [SUM_W-1:0] sum_x      = '0;
  logic [SUM_W-1:0] sum_y      = '0;
  logic [CNT_W-1:0] ok_cnt     = '0;
  logic [CNT_W-1:0] fail_cnt   = '0;
  logic [CNT_W-1:0] glitch_cnt = '0;

  cursor_report_t pending_reports [$];
  int  error_count = 0;
  int  typed_idx   = 0;
  bit  calm        = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_reg(input int unsigned lo, input int unsigned hi);
    return CFG_DATA_W'($urandom_range(lo, hi));
  endfunction

  function automatic bit predict_nibble(input logic [NIB_W-1:0] nib, input logic fst,
                                        output cursor_report_t rep);
    logic [MAG_W-1:0] mag_x, mag_y;
    int dx, dy, cx, cy;
    bit good;
    rep = '0;
    if (fst || nib_pos >= PACKET_NIBBLES_DEF) nib_pos = 0;
    nib_store[nib_pos] = nib;
    if (nib_pos + 1 < PACKET_NIBBLES_DEF) begin
      nib_pos++;
      return 1'b0;
    end
    nib_pos = 0;
    dx = 0;
    dy = 0;
    good = nib_store[0] == SIG_NIB0 && nib_store[1] == SIG_NIB1 && nib_store[2] == SIG_NIB2;
    if (good) begin
      ok_cnt++;
      rep.buttons = nib_store[4];
      mag_x = {nib_store[5], nib_store[6]};
      mag_y = {nib_store[7], nib_store[8]};
      if (mag_x > lim_max_delta || mag_y > lim_max_delta) begin
        rep.glitch = 1'b1;
        glitch_cnt++;
      end else begin
        dx = nib_store[3][0] ? -int'(mag_x) : int'(mag_x);
        dy = nib_store[3][1] ? -int'(mag_y) : int'(mag_y);
        sum_x = sum_x + 32'(dx);
        sum_y = sum_y + 32'(dy);
      end
    end else begin
      fail_cnt++;
    end
    // minimum first, maximum last: crossed bounds resolve to the maximum
    cx = int'(cur_x) + dx;
    if (cx < int'(lim_x_min)) cx = int'(lim_x_min);
    if (cx > int'(lim_x_max)) cx = int'(lim_x_max);
    cy = int'(cur_y) - dy;
    if (cy < int'(lim_y_min)) cy = int'(lim_y_min);
    if (cy > int'(lim_y_max)) cy = int'(lim_y_max);
    cur_x = 9'(cx);
    cur_y = 9'(cy);
    rep.packet_ok    = good;
    rep.delta_x      = 9'(dx);
    rep.delta_y      = 9'(dy);
    rep.cursor_x     = cur_x;
    rep.cursor_y     = cur_y;
    rep.total_x      = sum_x;
    rep.total_y      = sum_y;
    rep.ok_count     = ok_cnt;
    rep.fail_count   = fail_cnt;
    rep.glitch_count = glitch_cnt;
    return 1'b1;
  endfunction

  task automatic send_nibble(input logic [NIB_W-1:0] nib, input logic fst, input bit typed);
    int gap;
    cursor_report_t rep;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid  <= 1'b1;
    in_bus.nibble <= nib;
    in_bus.first  <= fst;
    do @(posedge clk_i); while (!in_bus.ready);
    if (predict_nibble(nib, fst, rep)) begin
      if (typed) begin
        pending_reports.push_back(DIR_REPORTS[typed_idx]);
        typed_idx++;
      end else begin
        pending_reports.push_back(rep);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cfg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      CFG_MAX_DELTA: lim_max_delta = data[MAG_W-1:0];
      CFG_X_MIN:     lim_x_min = data;
      CFG_X_MAX:     lim_x_max = data;
      CFG_Y_MIN:     lim_y_min = data;
      CFG_Y_MAX:     lim_y_max = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [MAG_W-1:0] pick_mag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return MAG_W'($urandom_range(0, lim_max_delta));
    if (r < 80) begin
      if (lim_max_delta == 8'hFF) return lim_max_delta;
      return MAG_W'(lim_max_delta + $urandom_range(0, 1));
    end
    return MAG_W'($urandom_range(0, 255));
  endfunction

  task automatic send_packet(input int len, input bit sig_ok);
    logic [NIB_W-1:0] pkt [PACKET_NIBBLES_DEF];
    logic [MAG_W-1:0] mx, my;
    logic fst;
    fst = (nib_pos != 0) || ($urandom_range(0, 3) != 0);
    mx = pick_mag();
    my = pick_mag();
    pkt[0] = sig_ok ? SIG_NIB0 : NIB_W'($urandom_range(0, 15));
    pkt[1] = sig_ok ? SIG_NIB1 : NIB_W'($urandom_range(0, 15));
    pkt[2] = sig_ok ? SIG_NIB2 : NIB_W'($urandom_range(0, 15));
    pkt[3] = NIB_W'($urandom_range(0, 15));
    pkt[4] = NIB_W'($urandom_range(0, 15));
    pkt[5] = mx[7:4];
    pkt[6] = mx[3:0];
    pkt[7] = my[7:4];
    pkt[8] = my[3:0];
    for (int i = 0; i < len; i++) send_nibble(pkt[i], (i == 0) ? fst : 1'b0, 1'b0);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] md, xl, xh, yl, yh, input bit steady);
    int sent, r, len;
    drain();
    calm = steady;
    write_reg(CFG_MAX_DELTA, md);
    write_reg(CFG_X_MIN, xl);
    write_reg(CFG_X_MAX, xh);
    write_reg(CFG_Y_MIN, yl);
    write_reg(CFG_Y_MAX, yh);
    write_reg(CFG_IDX_W'($urandom_range(CFG_Y_MAX + 1, 2**CFG_IDX_W - 1)), rand_reg(0, 511));
    cfg_bus.valid <= 1'b0;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_packet(PACKET_NIBBLES_DEF, $urandom_range(0, 9) != 0);
        sent += PACKET_NIBBLES_DEF;
      end else if (r < 90) begin
        // truncated packet, the next one restarts
        len = $urandom_range(1, PACKET_NIBBLES_DEF - 1);
        send_packet(len, 1'b1);
        sent += len;
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
          send_nibble(NIB_W'($urandom_range(0, 15)), $urandom_range(0, 9) < 3, 1'b0);
        sent += len;
      end
    end
  endtask

  initial begin
    int hold;
    hold = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else begin
        hold = pick_gap();
        out_bus.ready <= (hold == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    cursor_report_t got, want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.packet_ok    = out_bus.packet_ok;
      got.delta_x      = out_bus.delta_x;
      got.delta_y      = out_bus.delta_y;
      got.buttons      = out_bus.buttons;
      got.glitch       = out_bus.glitch;
      got.cursor_x     = out_bus.cursor_x;
      got.cursor_y     = out_bus.cursor_y;
      got.total_x      = out_bus.total_x;
      got.total_y      = out_bus.total_y;
      got.ok_count     = out_bus.ok_count;
      got.fail_count   = out_bus.fail_count;
      got.glitch_count = out_bus.glitch_count;
      if (pending_reports.size() == 0) begin
        if (error_count < MAX_REPORTED)
          $display("%0t: unexpected result transfer", $realtime);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          if (error_count < MAX_REPORTED) begin
            $display(
              "%0t: exp ok=%0d dx=%0d dy=%0d btn=%h gl=%0d cur=%0d,%0d tot=%0d,%0d cnt=%0d/%0d/%0d",
              $realtime, want.packet_ok, want.delta_x, want.delta_y, want.buttons,
              want.glitch, want.cursor_x, want.cursor_y, want.total_x, want.total_y,
              want.ok_count, want.fail_count, want.glitch_count);
            $display(
              "%0t: got ok=%0d dx=%0d dy=%0d btn=%h gl=%0d cur=%0d,%0d tot=%0d,%0d cnt=%0d/%0d/%0d",
              $realtime, got.packet_ok, got.delta_x, got.delta_y, got.buttons,
              got.glitch, got.cursor_x, got.cursor_y, got.total_x, got.total_y,
              got.ok_count, got.fail_count, got.glitch_count);
          end
          error_count++;
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_bus.valid && in_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
          (out_bus.valid && out_bus.ready))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("tb_nibble_mouse_packet_cursor_tracker NOT OK");
    $finish;
  end

  initial begin
    in_bus.valid  <= 1'b0;
    in_bus.nibble <= '0;
    in_bus.first  <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data  <= '0;
    rst_ni        <= 1'b0;
    foreach (nib_store[i]) nib_store[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_nibble(DIR_TABLE[i][NIB_W-1:0], DIR_TABLE[i][NIB_W], 1'b1);

    run_phase(9'h1FF, 9'd0, 9'd511, 9'd0, 9'd511, 1'b0);
    run_phase(9'd0, 9'd511, 9'd0, 9'd300, 9'd20, 1'b1);
    run_phase(rand_reg(0, 511), rand_reg(0, 511), rand_reg(0, 511),
              rand_reg(0, 511), rand_reg(0, 511), 1'b0);
    run_phase(9'd30, 9'd100, 9'd120, 9'd200, 9'd210, 1'b0);
    run_phase(rand_reg(0, 511), rand_reg(0, 255), rand_reg(256, 511),
              rand_reg(0, 255), rand_reg(256, 511), 1'b0);
    run_phase(rand_reg(0, 511), rand_reg(0, 511), rand_reg(0, 511),
              rand_reg(0, 511), rand_reg(0, 511), 1'b1);

    drain();
    if (error_count == 0)
      $display("tb_nibble_mouse_packet_cursor_tracker OK");
    else
      $display("tb_nibble_mouse_packet_cursor_tracker NOT OK");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/nmpct_pkg.sv
rtl/nmpct_in_if.sv
rtl/nmpct_out_if.sv
rtl/nmpct_cfg_if.sv
rtl/nmpct_fifo.sv
rtl/nmpct_front.sv
rtl/nmpct_back.sv
rtl/nibble_mouse_packet_cursor_tracker.sv
rtl/nmpct_checker.sv
bench/tb_nibble_mouse_packet_cursor_tracker.sv
